### rtl/core/iidl_pkg.sv
// Shared types and codes for the indexed insert/delete list.
`default_nettype none

package iidl_pkg;

  typedef enum logic [3:0] {
    KIND_PUSH_BACK  = 4'd0,
    KIND_PUSH_FRONT = 4'd1,
    KIND_INSERT     = 4'd2,
    KIND_ERASE      = 4'd3,
    KIND_POP_BACK   = 4'd4,
    KIND_POP_FRONT  = 4'd5,
    KIND_READ       = 4'd6,
    KIND_WRITE      = 4'd7,
    KIND_CLEAR      = 4'd8
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Broadcast to every cell for one request
  typedef struct packed {
    logic shift_up;    // cells above pos take their lower neighbour
    logic shift_down;  // cells at and above pos take their upper neighbour
    logic load;        // cell at pos takes the new word
  } cell_ctrl_t;

endpackage

`default_nettype wire

### rtl/core/iidl_cell.sv
// One storage cell of the list: holds one word and shifts to/from its neighbours.
`default_nettype none

module iidl_cell
  import iidl_pkg::*;
#(
  parameter int WORD_BITS = 32,
  parameter int CW        = 6,
  parameter int INDEX     = 0
) (
  input  wire logic                 clk,
  input  wire cell_ctrl_t           ctrl,
  input  wire logic [CW-1:0]        pos,
  input  wire logic [WORD_BITS-1:0] new_word,
  input  wire logic [WORD_BITS-1:0] lower_word,
  input  wire logic [WORD_BITS-1:0] upper_word,
  output logic      [WORD_BITS-1:0] cell_word
);

  logic [WORD_BITS-1:0] word_r;
  logic [WORD_BITS-1:0] word_nxt;
  logic                 above;
  logic                 at;

  assign above = CW'(INDEX) > pos;
  assign at    = CW'(INDEX) == pos;

  always_comb begin
    word_nxt = word_r;
    if (ctrl.shift_up && above) begin
      word_nxt = lower_word;
    end else if (ctrl.shift_down && (above || at)) begin
      word_nxt = upper_word;
    end else if (ctrl.load && at) begin
      word_nxt = new_word;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign cell_word = word_r;

endmodule

`default_nettype wire

### rtl/core/indexed_insert_delete_list.sv
// Top level of the indexed insert/delete list: a row of shifting cells and a request decoder.
// A result word is registered and appears in the cycle after its request word is accepted.
// Throughput: one request per cycle while the input is not stalled; every cell shifts
// in the cycle that takes the request. Input stalls only while a result waits under out_stall.
// Reset (synchronous, rst_n low): element count and result valid clear; cell
// contents are not cleared and are only read once written.
`default_nettype none

module indexed_insert_delete_list
  import iidl_pkg::*;
#(
  parameter int DEPTH     = 32,
  parameter int WORD_BITS = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [3:0]         in_kind,
  input  wire logic [5:0]         in_position,
  input  wire logic signed [31:0] in_element_value,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      out_read_value,
  output logic [5:0]              out_element_count,
  output logic [1:0]              out_status
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);
  localparam int PW = (CW > 6) ? CW : 6;

  logic [CW-1:0]           cnt_r;
  logic [CW-1:0]           cnt_nxt;
  logic                    out_valid_r;
  logic signed [31:0]      out_read_value_r;
  logic [5:0]              out_element_count_r;
  logic [1:0]              out_status_r;

  logic                    in_fire;
  logic                    full;
  logic                    empty;
  logic [PW-1:0]           pos_w;
  logic [PW-1:0]           cnt_w;
  cell_ctrl_t              ctrl;
  cell_ctrl_t              ctrl_q;
  logic [CW-1:0]           cell_pos;
  logic [CW-1:0]           rd_pos;
  logic                    rd_en;
  status_t                 status;
  logic [WORD_BITS-1:0]    new_word;
  logic signed [63:0]      in_ext;
  logic signed [WORD_BITS-1:0] rd_word;
  logic signed [63:0]      rd_ext;
  logic signed [31:0]      read_value;
  logic [WORD_BITS-1:0]    cell_words [DEPTH];

  // A finished result blocks the input only while the consumer stalls it
  assign in_stall = out_valid_r && out_stall;
  assign in_fire  = in_valid && !in_stall;

  assign full  = cnt_r == CW'(DEPTH);
  assign empty = cnt_r == '0;
  assign pos_w = PW'(in_position);
  assign cnt_w = PW'(cnt_r);

  assign in_ext   = 64'(in_element_value);
  assign new_word = in_ext[WORD_BITS-1:0];

  always_comb begin
    ctrl     = '0;
    cell_pos = cnt_r;
    rd_pos   = '0;
    rd_en    = 1'b0;
    status   = ST_OK;
    cnt_nxt  = cnt_r;
    unique case (kind_t'(in_kind))
      KIND_PUSH_BACK: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          ctrl.load = 1'b1;
          cell_pos  = cnt_r;
          cnt_nxt   = CW'(cnt_r + 1'b1);
        end
      end
      KIND_PUSH_FRONT: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          ctrl.shift_up = 1'b1;
          ctrl.load     = 1'b1;
          cell_pos      = '0;
          cnt_nxt       = CW'(cnt_r + 1'b1);
        end
      end
      KIND_INSERT: begin
        // out-of-range position takes priority over the full check
        if (pos_w > cnt_w) begin
          status = ST_RANGE;
        end else if (full) begin
          status = ST_FULL;
        end else begin
          ctrl.shift_up = 1'b1;
          ctrl.load     = 1'b1;
          cell_pos      = CW'(pos_w);
          cnt_nxt       = CW'(cnt_r + 1'b1);
        end
      end
      KIND_ERASE: begin
        if (pos_w >= cnt_w) begin
          status = ST_RANGE;
        end else begin
          rd_en           = 1'b1;
          rd_pos          = CW'(pos_w);
          ctrl.shift_down = 1'b1;
          cell_pos        = CW'(pos_w);
          cnt_nxt         = CW'(cnt_r - 1'b1);
        end
      end
      KIND_POP_BACK: begin
        if (empty) begin
          status = ST_RANGE;
        end else begin
          rd_en   = 1'b1;
          rd_pos  = CW'(cnt_r - 1'b1);
          cnt_nxt = CW'(cnt_r - 1'b1);
        end
      end
      KIND_POP_FRONT: begin
        if (empty) begin
          status = ST_RANGE;
        end else begin
          rd_en           = 1'b1;
          rd_pos          = '0;
          ctrl.shift_down = 1'b1;
          cell_pos        = '0;
          cnt_nxt         = CW'(cnt_r - 1'b1);
        end
      end
      KIND_READ: begin
        if (pos_w >= cnt_w) begin
          status = ST_RANGE;
        end else begin
          rd_en  = 1'b1;
          rd_pos = CW'(pos_w);
        end
      end
      KIND_WRITE: begin
        if (pos_w >= cnt_w) begin
          status = ST_RANGE;
        end else begin
          ctrl.load = 1'b1;
          cell_pos  = CW'(pos_w);
        end
      end
      KIND_CLEAR: begin
        cnt_nxt = '0;
      end
      default: begin
        // unused kinds: no effect
      end
    endcase
  end

  assign ctrl_q = in_fire ? ctrl : '0;

  // Row of cells; the ends see their own word as the missing neighbour
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_BITS-1:0] lower_word;
    logic [WORD_BITS-1:0] upper_word;

    if (i == 0) begin : g_first
      assign lower_word = cell_words[i];
    end else begin : g_mid_lo
      assign lower_word = cell_words[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign upper_word = cell_words[i];
    end else begin : g_mid_hi
      assign upper_word = cell_words[i+1];
    end

    iidl_cell #(
      .WORD_BITS (WORD_BITS),
      .CW        (CW),
      .INDEX     (i)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl_q),
      .pos        (cell_pos),
      .new_word   (new_word),
      .lower_word (lower_word),
      .upper_word (upper_word),
      .cell_word  (cell_words[i])
    );
  end

  // rd_pos is below count whenever rd_en is set, so it fits the index
  assign rd_word    = cell_words[rd_pos[IW-1:0]];
  assign rd_ext     = 64'(rd_word);
  assign read_value = rd_en ? rd_ext[31:0] : 32'sd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        cnt_r       <= cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_read_value_r    <= read_value;
      out_element_count_r <= 6'(cnt_nxt);
      out_status_r        <= status;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_read_value    = out_read_value_r;
  assign out_element_count = out_element_count_r;
  assign out_status        = out_status_r;

endmodule

`default_nettype wire

### rtl/core/iidl_checker.sv
// Port-level assertions for the indexed insert/delete list, bound to the top level.
`default_nettype none

module iidl_checker
  import iidl_pkg::*;
#(
  parameter int DEPTH = 32
) (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic [3:0]         in_kind,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic signed [31:0] out_read_value,
  input wire logic [5:0]         out_element_count,
  input wire logic [1:0]         out_status
);

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (int'(out_element_count) <= DEPTH))
    else $error("element count above list depth");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_FULL) |-> out_element_count == 6'(DEPTH))
    else $error("full status with a list that is not full");

  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> out_read_value == 32'sd0)
    else $error("refused request returned a word");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_kind == KIND_CLEAR) |=>
      (out_valid && out_element_count == 6'd0 && out_status == ST_OK))
    else $error("clear did not empty the list");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_read_value) && $stable(out_element_count)
       && $stable(out_status)))
    else $error("stalled result word changed");

endmodule

bind indexed_insert_delete_list iidl_checker #(.DEPTH(DEPTH)) u_iidl_checker (.*);

`default_nettype wire

### verif/iidl_list_checker.sv
// Checker for the indexed insert/delete list: predicts each reply word and compares it.
module iidl_list_checker
  import iidl_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [3:0]         in_kind,
  input  logic [5:0]         in_position,
  input  logic signed [31:0] in_element_value,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] out_read_value,
  input  logic [5:0]         out_element_count,
  input  logic [1:0]         out_status,
  output int                 fault_count,
  output int                 pending,
  output int                 list_len
);

  localparam int LIST_DEPTH = 32;
  localparam int REPORT_MAX = 10;

  typedef struct {
    logic signed [31:0] value;
    logic [5:0]         count;
    status_t            status;
  } list_reply_t;

  logic signed [31:0] cells [0:LIST_DEPTH-1];
  int                 len;
  int                 faults;
  int                 replies_seen;
  list_reply_t        replies_due [$];
  list_reply_t        want;

  initial begin
    len          = 0;
    faults       = 0;
    replies_seen = 0;
  end

  // Applies one request word to the shadow list and returns the reply it should give
  function automatic list_reply_t apply_request(input logic [3:0] k, input logic [5:0] p,
                                                input logic signed [31:0] v);
    list_reply_t r;
    int          i;
    r.value  = '0;
    r.status = ST_OK;
    case (k)
      KIND_PUSH_BACK: begin
        if (len >= LIST_DEPTH) r.status = ST_FULL;
        else begin
          cells[len] = v;
          len++;
        end
      end
      KIND_PUSH_FRONT: begin
        if (len >= LIST_DEPTH) r.status = ST_FULL;
        else begin
          for (i = len; i > 0; i--) cells[i] = cells[i-1];
          cells[0] = v;
          len++;
        end
      end
      KIND_INSERT: begin
        // range check takes priority over the full check
        if (int'(p) > len) r.status = ST_RANGE;
        else if (len >= LIST_DEPTH) r.status = ST_FULL;
        else begin
          for (i = len; i > int'(p); i--) cells[i] = cells[i-1];
          cells[p] = v;
          len++;
        end
      end
      KIND_ERASE: begin
        if (int'(p) >= len) r.status = ST_RANGE;
        else begin
          r.value = cells[p];
          for (i = int'(p); i + 1 < len; i++) cells[i] = cells[i+1];
          len--;
        end
      end
      KIND_POP_BACK: begin
        if (len == 0) r.status = ST_RANGE;
        else begin
          len--;
          r.value = cells[len];
        end
      end
      KIND_POP_FRONT: begin
        if (len == 0) r.status = ST_RANGE;
        else begin
          r.value = cells[0];
          for (i = 0; i + 1 < len; i++) cells[i] = cells[i+1];
          len--;
        end
      end
      KIND_READ: begin
        if (int'(p) >= len) r.status = ST_RANGE;
        else r.value = cells[p];
      end
      KIND_WRITE: begin
        if (int'(p) >= len) r.status = ST_RANGE;
        else cells[p] = v;
      end
      KIND_CLEAR: len = 0;
      default: ;  // unused kinds leave the list alone
    endcase
    r.count = len[5:0];
    return r;
  endfunction

  function automatic void note_fault(input string what);
    faults++;
    if (faults <= REPORT_MAX) $display("reply %0d: %s", replies_seen, what);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      len = 0;
      replies_due.delete();
    end else begin
      if (in_valid && !in_stall)
        replies_due = {replies_due, apply_request(in_kind, in_position, in_element_value)};
      if (out_valid && !out_stall) begin
        if (replies_due.size() == 0) begin
          note_fault($sformatf("unexpected word: value %0d count %0d status %0d",
                               out_read_value, out_element_count, out_status));
        end else begin
          want = replies_due[0];
          replies_due.delete(0);
          if (out_read_value !== want.value || out_element_count !== want.count ||
              out_status !== want.status)
            note_fault($sformatf(
              "expected value %0d count %0d status %0d, got value %0d count %0d status %0d",
              want.value, want.count, want.status,
              out_read_value, out_element_count, out_status));
        end
        replies_seen++;
      end
    end
    pending     <= replies_due.size();
    fault_count <= faults;
    list_len    <= len;
  end

endmodule

### verif/indexed_insert_delete_list_tb.sv
// Testbench top for the indexed insert/delete list: clock, reset, request stimulus and verdict.
module indexed_insert_delete_list_tb;
  import iidl_pkg::*;

  localparam int PHASE_LEN   = 50;
  localparam int PHASES      = 11;
  localparam int HOLD_CYCLES = 60;
  localparam int CYCLE_LIMIT = 200000;

  typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIX} mix_mode_t;

  logic               clk;
  logic               rst_n            = 1'b0;
  logic               in_valid         = 1'b0;
  logic               in_stall;
  logic [3:0]         in_kind          = '0;
  logic [5:0]         in_position      = '0;
  logic signed [31:0] in_element_value = '0;
  logic               out_valid;
  logic               out_stall        = 1'b0;
  logic signed [31:0] out_read_value;
  logic [5:0]         out_element_count;
  logic [1:0]         out_status;

  int fault_count;
  int pending;
  int list_len;

  bit calm  = 1'b0;  // neither side idles
  bit press = 1'b0;  // sender offers back to back
  int hold_asks   = 0;
  int hold_served = 0;
  int cycles      = 0;

  mix_mode_t phase_mode [PHASES] = '{MODE_FILL, MODE_FILL, MODE_MIX, MODE_DRAIN, MODE_MIX,
                                     MODE_FILL, MODE_FILL, MODE_MIX, MODE_DRAIN, MODE_DRAIN,
                                     MODE_MIX};

  indexed_insert_delete_list u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_kind           (in_kind),
    .in_position       (in_position),
    .in_element_value  (in_element_value),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_read_value    (out_read_value),
    .out_element_count (out_element_count),
    .out_status        (out_status)
  );

  iidl_list_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_kind           (in_kind),
    .in_position       (in_position),
    .in_element_value  (in_element_value),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_read_value    (out_read_value),
    .out_element_count (out_element_count),
    .out_status        (out_status),
    .fault_count       (fault_count),
    .pending           (pending),
    .list_len          (list_len)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  // Reply side: random stalls, plus a long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_asks != hold_served) begin
        hold_served = hold_asks;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 35);
      end
    end
  end

  // Offers one request word, maybe after a gap, and returns at the edge that takes it
  task automatic send_word(input logic [3:0] k, input logic [5:0] p, input logic [31:0] v);
    if (!calm && !press && $urandom_range(0, 99) < 35) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_kind          <= k;
    in_position      <= p;
    in_element_value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_replies();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'h0;
      3:       return 32'hffff_ffff;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [3:0] pick_kind(input mix_mode_t mode);
    int r;
    r = $urandom_range(0, 99);
    case (mode)
      MODE_FILL: begin
        if (r < 30) return KIND_PUSH_BACK;
        if (r < 50) return KIND_PUSH_FRONT;
        if (r < 70) return KIND_INSERT;
        if (r < 75) return KIND_ERASE;
        if (r < 80) return KIND_POP_BACK;
        if (r < 85) return KIND_POP_FRONT;
        if (r < 90) return KIND_READ;
        if (r < 97) return KIND_WRITE;
      end
      MODE_DRAIN: begin
        if (r < 5)  return KIND_PUSH_BACK;
        if (r < 10) return KIND_PUSH_FRONT;
        if (r < 15) return KIND_INSERT;
        if (r < 40) return KIND_ERASE;
        if (r < 60) return KIND_POP_BACK;
        if (r < 80) return KIND_POP_FRONT;
        if (r < 88) return KIND_READ;
        if (r < 96) return KIND_WRITE;
        if (r < 97) return KIND_CLEAR;
      end
      default: begin
        if (r < 11) return KIND_PUSH_BACK;
        if (r < 22) return KIND_PUSH_FRONT;
        if (r < 33) return KIND_INSERT;
        if (r < 44) return KIND_ERASE;
        if (r < 55) return KIND_POP_BACK;
        if (r < 66) return KIND_POP_FRONT;
        if (r < 79) return KIND_READ;
        if (r < 92) return KIND_WRITE;
        if (r < 95) return KIND_CLEAR;
      end
    endcase
    // unused kind codes
    return 4'($urandom_range(9, 15));
  endfunction

  initial begin
    logic [3:0] k;
    logic [5:0] p;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty list, extremes, ends of the list, bad positions, clear
    send_word(KIND_POP_BACK,   6'd0,  32'h0);
    send_word(KIND_POP_FRONT,  6'd0,  32'h0);
    send_word(KIND_ERASE,      6'd0,  32'h0);
    send_word(KIND_READ,       6'd0,  32'h0);
    send_word(KIND_WRITE,      6'd0,  32'h1);
    send_word(KIND_INSERT,     6'd1,  32'h2);
    send_word(KIND_INSERT,     6'd0,  32'h7fff_ffff);
    send_word(KIND_PUSH_BACK,  6'd0,  32'h8000_0000);
    send_word(KIND_PUSH_FRONT, 6'd0,  32'h0);
    send_word(KIND_INSERT,     6'd3,  32'hffff_ffff);
    send_word(KIND_INSERT,     6'd63, 32'h3);
    send_word(KIND_READ,       6'd0,  32'h0);
    send_word(KIND_READ,       6'd3,  32'h0);
    send_word(KIND_READ,       6'd4,  32'h0);
    send_word(KIND_WRITE,      6'd1,  32'h5555_5555);
    send_word(KIND_READ,       6'd1,  32'h0);
    send_word(KIND_ERASE,      6'd0,  32'h0);
    send_word(KIND_ERASE,      6'd32, 32'h0);
    send_word(KIND_POP_BACK,   6'd0,  32'h0);
    send_word(KIND_POP_FRONT,  6'd0,  32'h0);
    send_word(4'd9,            6'd0,  32'h0);
    send_word(4'd15,           6'd63, 32'haaaa_aaaa);
    send_word(KIND_CLEAR,      6'd0,  32'h0);
    send_word(KIND_READ,       6'd0,  32'h0);
    send_word(KIND_PUSH_BACK,  6'd0,  32'h1234_5678);

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == 2) begin
        // long reply hold-off while requests keep coming: the list backs up
        press = 1'b1;
        hold_asks++;
      end else begin
        press = 1'b0;
      end
      if (ph == 4) wait_replies();
      calm = (ph == 5);
      for (int n = 0; n < PHASE_LEN; n++) begin
        k = pick_kind(phase_mode[ph]);
        // mostly positions near the live range, some anywhere in the field
        if ($urandom_range(0, 99) < 85) p = 6'($urandom_range(0, list_len));
        else p = 6'($urandom_range(0, 63));
        send_word(k, p, rand_word());
      end
    end
    calm  = 1'b0;
    press = 1'b0;

    wait_replies();
    repeat (10) @(posedge clk);
    if (fault_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
